// ===== design/gtnf_pkg.sv =====
// Shared types and constants of the gyro triple notch filter.
`default_nettype none
package gtnf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int BIAS_W     = 25;
  localparam int BIAS_FRAC  = 9;
  localparam int COEF_W     = 21;
  localparam int COEF_REG_W = 63;
  localparam int OUT_W      = 32;
  localparam int DELAY_W    = 40;
  localparam int N_STAGES   = 3;
  localparam int CFG_IDX_W  = 2;

  // packed coefficient register layout
  localparam int B0_LSB = 42;
  localparam int A1_LSB = 21;
  localparam int A2_LSB = 0;

  // b0 = 1.0, a1 = -2.0, a2 = 1.0: passes samples unchanged
  localparam logic [COEF_REG_W-1:0] COEF_RESET = 63'd576464600594251776;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIAS,
    CFG_STAGE1,
    CFG_STAGE2,
    CFG_STAGE3
  } cfg_reg_e;

  // word handed from one section cell to the next
  typedef struct packed {
    logic                    valid;
    logic signed [OUT_W-1:0] sample;
    logic                    sat;
  } link_t;

endpackage
`default_nettype wire

// ===== design/gtnf_cell.sv =====
// One notch biquad section: four-step cell holding its own pair of delays.
`default_nettype none
module gtnf_cell #(
  parameter int CoefFracBits = 17
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [gtnf_pkg::COEF_REG_W-1:0]       coeffs_i,
  input  wire gtnf_pkg::link_t                       link_i,
  output gtnf_pkg::link_t                            link_o
);

  localparam int OutW   = gtnf_pkg::OUT_W;
  localparam int DelayW = gtnf_pkg::DELAY_W;
  localparam int CoefW  = gtnf_pkg::COEF_W;
  localparam int ProdW  = CoefW + OutW;
  localparam int DiffW  = OutW + 1;
  localparam int Prod1W = CoefW + DiffW;
  localparam int AccW   = DelayW + CoefFracBits + 3;

  localparam logic signed [AccW-1:0] Half =
    {{(AccW-CoefFracBits){1'b0}}, 1'b1, {(CoefFracBits-1){1'b0}}};
  localparam logic signed [AccW-1:0] OutHi = {{(AccW-OutW+1){1'b0}}, {(OutW-1){1'b1}}};
  localparam logic signed [AccW-1:0] OutLo = {{(AccW-OutW+1){1'b1}}, {(OutW-1){1'b0}}};
  localparam logic signed [AccW-1:0] DlyHi = {{(AccW-DelayW+1){1'b0}}, {(DelayW-1){1'b1}}};
  localparam logic signed [AccW-1:0] DlyLo = {{(AccW-DelayW+1){1'b1}}, {(DelayW-1){1'b0}}};
  localparam logic signed [OutW-1:0]   OutMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic signed [OutW-1:0]   OutMin = {1'b1, {(OutW-1){1'b0}}};
  localparam logic signed [DelayW-1:0] DlyMax = {1'b0, {(DelayW-1){1'b1}}};
  localparam logic signed [DelayW-1:0] DlyMin = {1'b1, {(DelayW-1){1'b0}}};

  logic signed [CoefW-1:0] b0, a1, a2;

  logic v1_q, v2_q, v3_q;
  logic signed [OutW-1:0]   x1_q, y2_q;
  logic signed [ProdW-1:0]  p0_q, p2_q;
  logic signed [Prod1W-1:0] p1_q;
  logic                     s1_q, s2_q;
  logic signed [DelayW-1:0] d1_q, d2_q;
  logic                     out_valid_q;
  logic signed [OutW-1:0]   out_sample_q;
  logic                     out_sat_q;

  logic signed [AccW-1:0]   acc0, acc1, acc2, r0, r1, r2;
  logic signed [DiffW-1:0]  diff;
  logic signed [OutW-1:0]   y_d;
  logic signed [DelayW-1:0] d1_d, d2_d;
  logic                     f0, f1, f2;

  assign b0 = signed'(coeffs_i[gtnf_pkg::B0_LSB +: CoefW]);
  assign a1 = signed'(coeffs_i[gtnf_pkg::A1_LSB +: CoefW]);
  assign a2 = signed'(coeffs_i[gtnf_pkg::A2_LSB +: CoefW]);

  // section output: round(b0*x + d1), clipped to 32 bits
  always_comb begin
    acc0 = AccW'(p0_q) + (AccW'(d1_q) <<< CoefFracBits) + Half;
    r0   = acc0 >>> CoefFracBits;
    f0   = 1'b0;
    if (r0 > OutHi) begin
      y_d = OutMax;
      f0  = 1'b1;
    end else if (r0 < OutLo) begin
      y_d = OutMin;
      f0  = 1'b1;
    end else begin
      y_d = r0[OutW-1:0];
    end
  end

  assign diff = DiffW'(x1_q) - DiffW'(y2_q);

  // delay updates, both clipped to 40 bits
  always_comb begin
    acc1 = AccW'(p1_q) + (AccW'(d2_q) <<< CoefFracBits) + Half;
    acc2 = AccW'(p0_q) - AccW'(p2_q) + Half;
    r1   = acc1 >>> CoefFracBits;
    r2   = acc2 >>> CoefFracBits;
    f1   = 1'b0;
    f2   = 1'b0;
    if (r1 > DlyHi) begin
      d1_d = DlyMax;
      f1   = 1'b1;
    end else if (r1 < DlyLo) begin
      d1_d = DlyMin;
      f1   = 1'b1;
    end else begin
      d1_d = r1[DelayW-1:0];
    end
    if (r2 > DlyHi) begin
      d2_d = DlyMax;
      f2   = 1'b1;
    end else if (r2 < DlyLo) begin
      d2_d = DlyMin;
      f2   = 1'b1;
    end else begin
      d2_d = r2[DelayW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
    end else begin
      v1_q        <= link_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
      if (v3_q) begin
        d1_q <= d1_d;
        d2_q <= d2_d;
      end
    end
  end

  // payload: each step loads only while its word is there, then holds
  always_ff @(posedge clk_i) begin
    if (link_i.valid) begin
      x1_q <= link_i.sample;
      s1_q <= link_i.sat;
      p0_q <= ProdW'(b0) * ProdW'(link_i.sample);
    end
    if (v1_q) begin
      y2_q <= y_d;
      s2_q <= s1_q | f0;
    end
    if (v2_q) begin
      p1_q <= Prod1W'(a1) * Prod1W'(diff);
      p2_q <= ProdW'(a2) * ProdW'(y2_q);
    end
    if (v3_q) begin
      out_sample_q <= y2_q;
      out_sat_q    <= s2_q | f1 | f2;
    end
  end

  assign link_o = '{valid: out_valid_q, sample: out_sample_q, sat: out_sat_q};

  // only one word inside a cell at a time
  a_one_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({link_i.valid, v1_q, v2_q, v3_q}))
    else $error("gtnf_cell: more than one word in flight");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_i.valid |-> ##4 out_valid_q)
    else $error("gtnf_cell: section result not out four cycles after entry");

  a_delays_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v3_q |=> ($stable(d1_q) && $stable(d2_q)))
    else $error("gtnf_cell: delays changed outside their update step");

endmodule
`default_nettype wire

// ===== design/gyro_triple_notch_filter_core.sv =====
// Gyro bias removal and three cascaded notch biquads, top level.
//
// Input channel: in_valid_i/in_ready_o with raw_sample_i, a signed 16-bit sample.
// Output channel: out_valid_o/out_ready_i with filtered_sample_o (signed, SAMPLE_FRAC_BITS
// fractional bits, saturated) and saturated_o, set if any section output or delay clipped.
// Config port: cfg_we_i, cfg_index_i, cfg_data_i; 0 bias, 1..3 packed section coefficients.
// Write config only while no word is in flight.
// Timing: the bias stage registers the bias-corrected sample, then each of the three
// section cells steps it through multiply, round to output, two multiplies and delay
// update; one word passes through at a time, so the next word is taken only after the
// previous one has left the last section cell.
// The output register plus a spare slot let the next word enter while a result waits;
// with both full, in_ready_o stays low until the receiver takes a word.
// Reset clears all delays, sets the bias to zero and loads coefficients that pass
// samples unchanged.
`default_nettype none
module gyro_triple_notch_filter_core #(
  parameter int COEF_FRAC_BITS   = 17,
  parameter int SAMPLE_FRAC_BITS = 9
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [gtnf_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [gtnf_pkg::COEF_REG_W-1:0]       cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [gtnf_pkg::SAMPLE_W-1:0]  raw_sample_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [gtnf_pkg::OUT_W-1:0]          filtered_sample_o,
  output logic                                       saturated_o
);

  localparam int OutW   = gtnf_pkg::OUT_W;
  localparam int NStg   = gtnf_pkg::N_STAGES;
  localparam int BiasUp = (SAMPLE_FRAC_BITS >= gtnf_pkg::BIAS_FRAC) ?
                          (SAMPLE_FRAC_BITS - gtnf_pkg::BIAS_FRAC) : 0;
  localparam int BiasDn = (SAMPLE_FRAC_BITS >= gtnf_pkg::BIAS_FRAC) ?
                          0 : (gtnf_pkg::BIAS_FRAC - SAMPLE_FRAC_BITS);

  logic signed [gtnf_pkg::BIAS_W-1:0] bias_q;
  logic [gtnf_pkg::COEF_REG_W-1:0]    coef_q [NStg];

  logic                   in_fire, out_fire, done;
  logic                   busy_q;
  logic signed [OutW-1:0] x0;
  logic                   launch_valid_q;
  logic signed [OutW-1:0] launch_sample_q;
  gtnf_pkg::link_t        links [NStg+1];

  logic                   out_valid_q, out_valid_d;
  logic signed [OutW-1:0] out_sample_q, out_sample_d;
  logic                   out_sat_q, out_sat_d;
  logic                   spare_valid_q, spare_valid_d;
  logic signed [OutW-1:0] spare_sample_q, spare_sample_d;
  logic                   spare_sat_q, spare_sat_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= '0;
      for (int i = 0; i < NStg; i++) coef_q[i] <= gtnf_pkg::COEF_RESET;
    end else if (cfg_we_i) begin
      case (gtnf_pkg::cfg_reg_e'(cfg_index_i))
        gtnf_pkg::CFG_BIAS:   bias_q   <= cfg_data_i[gtnf_pkg::BIAS_W-1:0];
        gtnf_pkg::CFG_STAGE1: coef_q[0] <= cfg_data_i;
        gtnf_pkg::CFG_STAGE2: coef_q[1] <= cfg_data_i;
        gtnf_pkg::CFG_STAGE3: coef_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !busy_q && !spare_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // bias is held with 9 fractional bits; below that it is a floor shift
  assign x0 = (OutW'(raw_sample_i) <<< SAMPLE_FRAC_BITS)
            - ((OutW'(bias_q) <<< BiasUp) >>> BiasDn);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_valid_q <= 1'b0;
    end else begin
      launch_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) launch_sample_q <= x0;
  end

  assign links[0] = '{valid: launch_valid_q, sample: launch_sample_q, sat: 1'b0};

  for (genvar g = 0; g < NStg; g++) begin : g_cell
    gtnf_cell #(
      .CoefFracBits(COEF_FRAC_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .coeffs_i(coef_q[g]),
      .link_i  (links[g]),
      .link_o  (links[g+1])
    );
  end

  assign done = links[NStg].valid;

  // output register with one spare slot behind it
  always_comb begin
    out_valid_d    = out_valid_q;
    out_sample_d   = out_sample_q;
    out_sat_d      = out_sat_q;
    spare_valid_d  = spare_valid_q;
    spare_sample_d = spare_sample_q;
    spare_sat_d    = spare_sat_q;
    if (out_fire) begin
      out_valid_d   = spare_valid_q;
      out_sample_d  = spare_sample_q;
      out_sat_d     = spare_sat_q;
      spare_valid_d = 1'b0;
    end
    if (done) begin
      if (!out_valid_d) begin
        out_valid_d  = 1'b1;
        out_sample_d = links[NStg].sample;
        out_sat_d    = links[NStg].sat;
      end else begin
        spare_valid_d  = 1'b1;
        spare_sample_d = links[NStg].sample;
        spare_sat_d    = links[NStg].sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      spare_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      out_valid_q   <= out_valid_d;
      spare_valid_q <= spare_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sample_q   <= out_sample_d;
    out_sat_q      <= out_sat_d;
    spare_sample_q <= spare_sample_d;
    spare_sat_q    <= spare_sat_d;
  end

  assign out_valid_o       = out_valid_q;
  assign filtered_sample_o = out_sample_q;
  assign saturated_o       = out_sat_q;

  a_spare_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_valid_q |-> out_valid_q)
    else $error("gtnf: spare slot full while output register empty");

  a_done_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy_q)
    else $error("gtnf: section chain finished a word that was never taken");

  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (busy_q && !in_ready_o))
    else $error("gtnf: second word taken while the chain is busy");

endmodule
`default_nettype wire
